// File: sv/ripemd128_hash_macros.svh
// Assertion macros shared by the RIPEMD-128 engine RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef RIPEMD128_HASH_MACROS_SVH
`define RIPEMD128_HASH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rmd128_pkg.sv
// Shared types, constants and round functions of the RIPEMD-128 engine.
// No dependencies.
package rmd128_pkg;

  localparam int unsigned BufWords = 16;
  localparam int unsigned BufAw    = 4;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  typedef logic [3:0][31:0] cv_t;

  // Control from the sequencer to the compression unit.
  typedef struct packed {
    logic start;    // begin one compression over the buffer
    logic iv_load;  // return the chaining value to the initial values
  } core_ctl_t;

  localparam cv_t IV = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

  localparam logic [3:0] SEL_L [64] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
    4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
    4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
    4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
    4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2};

  localparam logic [3:0] SEL_R [64] = '{
    4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
    4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
    4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
    4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
    4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
    4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
    4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
    4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14};

  localparam logic [3:0] ROT_L [64] = '{
    4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
    4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
    4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
    4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
    4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
    4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
    4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12};

  localparam logic [3:0] ROT_R [64] = '{
    4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
    4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
    4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
    4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
    4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
    4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
    4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
    4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8};

  localparam logic [31:0] K_L [4] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC};
  localparam logic [31:0] K_R [4] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3, 32'h00000000};

  function automatic logic [31:0] mix(input logic [1:0] kind, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    unique case (kind)
      2'd0: r = x ^ y ^ z;
      2'd1: r = (x & y) | (~x & z);
      2'd2: r = (x | ~y) ^ z;
      default: r = (x & z) | (y & ~z);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [3:0] s);
    logic [63:0] w;
    w = {v, v} << s;
    return w[63:32];
  endfunction

endpackage

// File: sv/rmd128_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module rmd128_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  output logic [Width-1:0]         rdata0_o,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

// File: sv/rmd128_core.sv
// RIPEMD-128 compression unit: one dual-line step per cycle, chaining value.
// Depends on rmd128_pkg and reads the message buffer through two RAM read ports.
`include "ripemd128_hash_macros.svh"
module rmd128_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rmd128_pkg::core_ctl_t      ctl_i,
  output logic [rmd128_pkg::BufAw-1:0] raddr_l_o,
  output logic [rmd128_pkg::BufAw-1:0] raddr_r_o,
  input  logic [31:0]                rdata_l_i,
  input  logic [31:0]                rdata_r_i,
  output logic                       done_o,
  output rmd128_pkg::cv_t            cv_o
);
  import rmd128_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_FOLD} core_state_e;

  core_state_e state_q;
  logic [6:0]  k_q;
  cv_t         cv_q;
  logic [31:0] a_q, b_q, c_q, d_q, ar_q, br_q, cr_q, dr_q;

  logic [5:0]  step;
  logic [1:0]  rnd;
  logic [31:0] tl, tr, nb, nbr;

  // Issue the word addresses a step ahead, so the registered RAM read lands with the step that uses them.
  assign raddr_l_o = SEL_L[k_q[5:0]];
  assign raddr_r_o = SEL_R[k_q[5:0]];

  assign step = k_q[5:0] - 6'd1;
  assign rnd  = step[5:4];

  always_comb begin
    tl  = a_q + mix(rnd, b_q, c_q, d_q) + rdata_l_i + K_L[rnd];
    nb  = rotl(tl, ROT_L[step]);
    tr  = ar_q + mix(2'd3 - rnd, br_q, cr_q, dr_q) + rdata_r_i + K_R[rnd];
    nbr = rotl(tr, ROT_R[step]);
  end

  assign cv_o = cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      k_q     <= '0;
      cv_q    <= IV;
      done_o  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      c_q     <= '0;
      d_q     <= '0;
      ar_q    <= '0;
      br_q    <= '0;
      cr_q    <= '0;
      dr_q    <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (ctl_i.iv_load) begin
            cv_q <= IV;
          end
          if (ctl_i.start) begin
            a_q  <= cv_q[0]; b_q  <= cv_q[1]; c_q  <= cv_q[2]; d_q  <= cv_q[3];
            ar_q <= cv_q[0]; br_q <= cv_q[1]; cr_q <= cv_q[2]; dr_q <= cv_q[3];
            k_q     <= '0;
            state_q <= C_RUN;
          end
        end
        C_RUN: begin
          if (k_q != 7'd0) begin
            a_q  <= d_q;  d_q  <= c_q;  c_q  <= b_q;  b_q  <= nb;
            ar_q <= dr_q; dr_q <= cr_q; cr_q <= br_q; br_q <= nbr;
          end
          if (k_q == 7'd64) begin
            state_q <= C_FOLD;
          end else begin
            k_q <= k_q + 7'd1;
          end
        end
        C_FOLD: begin
          cv_q[0] <= cv_q[1] + c_q + dr_q;
          cv_q[1] <= cv_q[2] + d_q + ar_q;
          cv_q[2] <= cv_q[3] + a_q + br_q;
          cv_q[3] <= cv_q[0] + b_q + cr_q;
          done_o  <= 1'b1;
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  `RMD_ASSERT_NOW(a_start_idle, ctl_i.start, state_q == C_IDLE, "start while compressing")
  `RMD_ASSERT_NEXT(a_run_end, (state_q == C_RUN) && (k_q == 7'd64), state_q == C_FOLD,
                   "step counter overran")
  `RMD_ASSERT_NOW(a_done_idle, done_o, (state_q == C_IDLE) && !ctl_i.start,
                  "done raised while busy")

endmodule

// File: sv/ripemd128_hash.sv
// RIPEMD-128 streaming engine, top level. Absorb item: one byte; the 64th byte of a
// block adds one compression, during which no input is taken.
// Finish item: padding words written into the buffer, one or two compressions,
// then four digest items at one per cycle as the output side takes them.
// One item at a time; the compression unit runs one step per cycle.
// Reset loads the initial chaining value and clears the byte count; no clearing pass.
`include "ripemd128_hash_macros.svh"
module ripemd128_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] mode
  // Digest items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast    // last
);
  import rmd128_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_FILL, S_WAIT, S_EMIT} top_state_e;

  top_state_e  state_q;
  logic [63:0] count_q;     // bytes absorbed, modulo 2^64
  logic [23:0] coll_q;      // lower bytes of the word being gathered
  logic [3:0]  wp_q;        // fill pointer for padding words
  logic        fin_q;       // compression belongs to a finish
  logic        two_q;       // padding needs an extra block
  logic [1:0]  idx_q;       // digest word on the output

  logic [5:0]  pos;
  logic [63:0] bits;
  logic        s_acc, m_acc;

  logic        we;
  logic [BufAw-1:0] waddr;
  logic [31:0] wdata;
  logic [31:0] pad_word, fill_word;

  core_ctl_t   ctl;
  logic [BufAw-1:0] raddr_l, raddr_r;
  logic [31:0] rdata_l, rdata_r;
  logic        core_done;
  cv_t         cv;

  assign pos   = count_q[5:0];
  assign bits  = {count_q[60:0], 3'b000};
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_EMIT);
  assign m_axis_tdata  = cv[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == 2'd3);

  // Padded word: gathered bytes below the position, 0x80 at it, zeros above.
  always_comb begin
    logic [31:0] lo;
    lo = {8'h00, coll_q};
    for (int b = 0; b < 4; b++) begin
      if (b < int'(pos[1:0])) begin
        pad_word[b*8 +: 8] = lo[b*8 +: 8];
      end else if (b == int'(pos[1:0])) begin
        pad_word[b*8 +: 8] = 8'h80;
      end else begin
        pad_word[b*8 +: 8] = 8'h00;
      end
    end
  end

  // Zero words, with the bit length in the last two words of the final block.
  always_comb begin
    priority if (!two_q && wp_q == 4'd14) begin
      fill_word = bits[31:0];
    end else if (!two_q && wp_q == 4'd15) begin
      fill_word = bits[63:32];
    end else begin
      fill_word = '0;
    end
  end

  // Buffer write port and compression control.
  always_comb begin
    we          = 1'b0;
    waddr       = pos[5:2];
    wdata       = {s_axis_tdata, coll_q};
    ctl.start   = 1'b0;
    ctl.iv_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc && s_axis_tuser == MODE_ABSORB) begin
          we        = (pos[1:0] == 2'd3);
          ctl.start = (pos == 6'd63);
        end
      end
      S_PAD: begin
        we        = 1'b1;
        wdata     = pad_word;
        ctl.start = (pos[5:2] == 4'd15);
      end
      S_FILL: begin
        we        = 1'b1;
        waddr     = wp_q;
        wdata     = fill_word;
        ctl.start = (wp_q == 4'd15);
      end
      S_WAIT: ;
      S_EMIT: ctl.iv_load = m_acc && (idx_q == 2'd3);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      coll_q  <= '0;
      wp_q    <= '0;
      fin_q   <= 1'b0;
      two_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            if (s_axis_tuser == MODE_ABSORB) begin
              // Gather the byte; a full word goes to the buffer.
              unique case (pos[1:0])
                2'd0: coll_q[7:0]   <= s_axis_tdata;
                2'd1: coll_q[15:8]  <= s_axis_tdata;
                2'd2: coll_q[23:16] <= s_axis_tdata;
                default: ;
              endcase
              count_q <= count_q + 64'd1;
              if (pos == 6'd63) begin
                fin_q   <= 1'b0;
                state_q <= S_WAIT;
              end
            end else begin
              fin_q   <= 1'b1;
              two_q   <= (pos >= 6'd56);
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pos[5:2] == 4'd15) begin
            state_q <= S_WAIT;
          end else begin
            wp_q    <= pos[5:2] + 4'd1;
            state_q <= S_FILL;
          end
        end
        S_FILL: begin
          if (wp_q == 4'd15) begin
            state_q <= S_WAIT;
          end else begin
            wp_q <= wp_q + 4'd1;
          end
        end
        S_WAIT: begin
          if (core_done) begin
            priority if (!fin_q) begin
              state_q <= S_IDLE;
            end else if (two_q) begin
              // Overflow block done: fill a block of zeros and the length.
              two_q   <= 1'b0;
              wp_q    <= '0;
              state_q <= S_FILL;
            end else begin
              idx_q   <= '0;
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (m_acc) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              count_q <= '0;
              fin_q   <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  rmd128_ram #(
    .Width(32),
    .Depth(BufWords)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(raddr_l),
    .rdata0_o(rdata_l),
    .raddr1_i(raddr_r),
    .rdata1_o(rdata_r)
  );

  rmd128_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .raddr_l_o(raddr_l),
    .raddr_r_o(raddr_r),
    .rdata_l_i(rdata_l),
    .rdata_r_i(rdata_r),
    .done_o   (core_done),
    .cv_o     (cv)
  );

  `RMD_ASSERT_NOW(a_no_write_in_comp, state_q == S_WAIT, !we,
                  "buffer written while compression reads it")
  `RMD_ASSERT_NOW(a_sides_apart, m_axis_tvalid, !s_axis_tready,
                  "input taken while digest pending")
  `RMD_ASSERT_NEXT(a_count_cleared, m_acc && m_axis_tlast,
                   (count_q == 64'd0) && (state_q == S_IDLE), "message state not restarted")

endmodule

// File: sim/tb_ripemd128_hash.sv
// Self-checking testbench for the ripemd128_hash streaming engine.
// Holds its own RIPEMD-128 predictor and compares every digest item against it.
// Depends on rmd128_pkg and the ripemd128_hash RTL.
`timescale 1ns / 100ps

module tb_ripemd128_hash;
  import rmd128_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000; // cycles with no item moving on either side
  localparam int unsigned HOLD_CYCLES    = 400;  // long output hold-off for the pressure test
  localparam int unsigned DRAIN_CYCLES   = 300;  // over two compressions plus padding

  // Message word order and rotate amounts of the left and right lines.
  localparam int unsigned SEL_LEFT [64] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
    7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
    3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
    1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2};
  localparam int unsigned SEL_RIGHT [64] = '{
    5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
    6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
    15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
    8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14};
  localparam int unsigned SHIFT_LEFT [64] = '{
    11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
    7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
    11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
    11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12};
  localparam int unsigned SHIFT_RIGHT [64] = '{
    8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
    9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
    9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
    15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8};
  localparam logic [31:0] ADD_LEFT  [4] = '{32'h00000000, 32'h5A827999,
                                             32'h6ED9EBA1, 32'h8F1BBCDC};
  localparam logic [31:0] ADD_RIGHT [4] = '{32'h50A28BE6, 32'h5C4DD124,
                                             32'h6D703EF3, 32'h00000000};
  localparam logic [31:0] INIT_CV   [4] = '{32'h67452301, 32'hEFCDAB89,
                                             32'h98BADCFE, 32'h10325476};

  typedef struct {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        is_last;
  } digest_item_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [31:0] digest_word
  logic [1:0]  m_axis_tuser;         // [1:0] word_index
  logic        m_axis_tlast;

  // Predictor state: chaining value, byte count, block bytes.
  logic [31:0]  chain_v [4];
  logic [63:0]  msg_byte_count;
  logic [7:0]   block_bytes [64];
  digest_item_t digest_q [$];

  int unsigned fail_count     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_seq   = 0; // bumped by a test to ask for a long hold-off
  int unsigned hold_seen_seq  = 0;
  int unsigned hold_left      = 0;

  ripemd128_hash dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] line_fn(input int unsigned sel, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z);
    case (sel)
      0:       return x ^ y ^ z;
      1:       return (x & y) | (~x & z);
      2:       return (x | ~y) ^ z;
      default: return (x & z) | (y & ~z);
    endcase
  endfunction

  // Run both lines over the block and fold them into the chaining value.
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, ar, br, cr, dr, t, top;
    int unsigned rnd;
    for (int k = 0; k < 16; k++) begin
      w[k] = {block_bytes[4*k+3], block_bytes[4*k+2], block_bytes[4*k+1], block_bytes[4*k]};
    end
    a = chain_v[0]; b = chain_v[1]; c = chain_v[2]; d = chain_v[3];
    ar = a; br = b; cr = c; dr = d;
    for (int i = 0; i < 64; i++) begin
      rnd = i / 16;
      t = a + line_fn(rnd, b, c, d) + w[SEL_LEFT[i]] + ADD_LEFT[rnd];
      t = rol32(t, SHIFT_LEFT[i]);
      a = d; d = c; c = b; b = t;
      t = ar + line_fn(3 - rnd, br, cr, dr) + w[SEL_RIGHT[i]] + ADD_RIGHT[rnd];
      t = rol32(t, SHIFT_RIGHT[i]);
      ar = dr; dr = cr; cr = br; br = t;
    end
    top        = chain_v[1] + c + dr;
    chain_v[1] = chain_v[2] + d + ar;
    chain_v[2] = chain_v[3] + a + br;
    chain_v[3] = chain_v[0] + b + cr;
    chain_v[0] = top;
  endfunction

  function automatic void restart_digest();
    for (int k = 0; k < 4; k++) chain_v[k] = INIT_CV[k];
    msg_byte_count = '0;
  endfunction

  // Advance the predictor by one accepted item; queue the digest on finish.
  function automatic void predict_digest(input logic mode, input logic [7:0] byte_val);
    int unsigned  pos;
    logic [63:0]  bit_len;
    digest_item_t item;
    pos = msg_byte_count[5:0];
    if (mode == MODE_ABSORB) begin
      block_bytes[pos] = byte_val;
      msg_byte_count   = msg_byte_count + 1;
      if (pos == 63) compress_block();
    end else begin
      bit_len = msg_byte_count << 3;
      block_bytes[pos] = 8'h80;
      for (int k = pos + 1; k < 64; k++) block_bytes[k] = 8'h00;
      // Length does not fit behind the marker: spill into a second block.
      if (pos >= 56) begin
        compress_block();
        for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) block_bytes[56+k] = bit_len[8*k +: 8];
      compress_block();
      for (int k = 0; k < 4; k++) begin
        item.digest_word = chain_v[k];
        item.word_index  = k[1:0];
        item.is_last     = (k == 3);
        digest_q.push_back(item);
      end
      restart_digest();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: ready with random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seen_seq != hold_req_seq) begin
      hold_seen_seq <= hold_req_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each digest item with the oldest expectation.
  always @(posedge clk_i) begin
    digest_item_t exp_item;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $error("unexpected digest item: word %h index %0d last %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        exp_item = digest_q.pop_front();
        if (m_axis_tdata !== exp_item.digest_word) begin
          $error("digest_word: expected %h, got %h", exp_item.digest_word, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser !== exp_item.word_index) begin
          $error("word_index: expected %0d, got %0d", exp_item.word_index, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tlast !== exp_item.is_last) begin
          $error("last: expected %0b, got %0b", exp_item.is_last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // End the run if no item moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ripemd128_hash: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Offer one item, idling first at random; keep valid high into the next item.
  task automatic send_item(input logic mode, input logic [7:0] byte_val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= byte_val;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_digest(mode, byte_val);
  endtask

  // Absorb len random bytes, then finish with a random (ignored) data byte.
  task automatic send_message(input int unsigned len);
    for (int k = 0; k < len; k++) send_item(MODE_ABSORB, 8'($urandom_range(255)));
    send_item(MODE_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic test_empty_message();
    send_item(MODE_FINISH, 8'h00);
    send_item(MODE_FINISH, 8'hFF);  // back to back: digest restarts from the initial values
  endtask

  task automatic test_directed_bytes();
    send_item(MODE_ABSORB, 8'h61);
    send_item(MODE_ABSORB, 8'h62);
    send_item(MODE_ABSORB, 8'h63);
    send_item(MODE_FINISH, 8'h00);
    send_item(MODE_ABSORB, 8'h00);
    send_item(MODE_ABSORB, 8'hFF);
    send_item(MODE_ABSORB, 8'h55);
    send_item(MODE_ABSORB, 8'hAA);
    send_item(MODE_ABSORB, 8'h01);
    send_item(MODE_ABSORB, 8'h80);
    send_item(MODE_FINISH, 8'hA5);
    send_item(MODE_ABSORB, 8'h7F);
    send_item(MODE_FINISH, 8'h5A);
  endtask

  // One full block absorbed, then a finish past the padding split (two more blocks).
  task automatic test_block_boundaries();
    send_message(121);
  endtask

  task automatic test_random_messages(input int unsigned n_items, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
    int unsigned sent;
    int unsigned len;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      // Short messages, each ending at a random spot in the word.
      len = $urandom_range(15);
      send_message(len);
      sent += len + 1;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Hold the output off while short messages keep coming, so the input stalls.
  task automatic test_output_backpressure();
    hold_req_seq++;
    for (int m = 0; m < 3; m++) send_message($urandom_range(3));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    restart_digest();
    for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;

    test_empty_message();
    test_directed_bytes();
    test_block_boundaries();
    test_random_messages(6, 0, 0);
    test_random_messages(6, 76, 0);
    test_random_messages(6, 0, 76);
    test_random_messages(6, 28, 28);
    test_output_backpressure();

    s_axis_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ripemd128_hash: match");
    end else begin
      $display("ripemd128_hash: mismatch");
    end
    $finish;
  end

endmodule
